// File: src/wpsc_pkg.sv
package wpsc_pkg;

  // Defaults for the top level parameters
  localparam int WINDOW_MAX_DEF = 32;
  localparam int VALUE_BITS_DEF = 48;

  // Window length register
  localparam int             LEN_BITS  = 6;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd25;
  localparam int             LEN_MIN   = 2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,   // waiting for a word, first read issued on accept
    S_LDX,    // outer operand arrives from the store
    S_CMP,    // one pair compared per cycle
    S_DONE    // result handed to the output register, store updated
  } state_t;

endpackage

// File: src/window_pair_sum_checker.sv
// Sliding-window pair-sum checker. Every input word comes back as one result word carrying
// the value, a checked flag (set once at least window_len earlier words are stored) and a
// has_pair flag (two distinct words of the last window_len words add up to the value).
// window_len is clamped to 2..WINDOW_MAX and may be written only while the block is idle.
// The pairs are searched by one adder and comparator fed from a one-read-port store, one
// pair per cycle, with a load of each outer operand from the store before its pairs; the
// search stops early when a pair is found and is skipped when the window is not yet full.
// The hand-off also waits while a stalled result still holds the output register. in_stall
// is high from the cycle after the accept until the hand-off.
// No clearing pass is needed after reset.
module window_pair_sum_checker
  import wpsc_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [LEN_BITS-1:0]   cfg_wr_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] echo_value,
  output logic                  checked,
  output logic                  has_pair
);

  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SW    = CNT_W + 1;
  localparam int CMP_W = (CNT_W > LEN_BITS) ? CNT_W : LEN_BITS;

  state_t state, state_next;

  logic [LEN_BITS-1:0]   cfg_len;
  logic [CNT_W-1:0]      len_eff;
  logic [CNT_W-1:0]      len_clamp;
  logic [AW-1:0]         write_slot;
  logic [CNT_W-1:0]      fill_count;
  logic [CNT_W-1:0]      idx_a;
  logic [CNT_W-1:0]      idx_b;
  logic [VALUE_BITS-1:0] x;
  logic [VALUE_BITS-1:0] v;
  logic                  chk;
  logic                  found;

  logic [CNT_W-1:0]      rd_back;
  logic [AW-1:0]         raddr;
  logic [VALUE_BITS-1:0] rdata;
  logic                  hit;
  logic                  last_b;
  logic                  last_a;
  logic                  accept;
  logic                  done_go;

  // Store slot of the word pushed 'back' steps ago
  function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] ws,
                                               input logic [CNT_W-1:0] back);
    logic [SW-1:0] t;
    t = SW'(ws) + SW'(WINDOW_MAX) - SW'(back);
    if (t >= SW'(WINDOW_MAX)) begin
      t = t - SW'(WINDOW_MAX);
    end
    return t[AW-1:0];
  endfunction

  // Clamp the length register to 2..WINDOW_MAX
  always_comb begin
    if (CMP_W'(cfg_len) < CMP_W'(LEN_MIN)) begin
      len_clamp = CNT_W'(LEN_MIN);
    end else if (CMP_W'(cfg_len) > CMP_W'(WINDOW_MAX)) begin
      len_clamp = CNT_W'(WINDOW_MAX);
    end else begin
      len_clamp = CNT_W'(cfg_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= LEN_RESET;
    end else if (cfg_wr_en) begin
      cfg_len <= cfg_wr_data;
    end
  end

  // Shared adder and comparator, sum kept one bit wider so it never wraps
  assign hit    = ({1'b0, x} + {1'b0, rdata}) == {1'b0, v};
  assign last_b = (idx_b == len_eff);
  assign last_a = ((idx_a + 1'b1) == len_eff);
  assign accept = in_valid && !in_stall;
  assign done_go = (state == S_DONE) && (!out_valid || !out_stall);
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and store read address
  always_comb begin
    state_next = state;
    rd_back    = CNT_W'(1);
    unique case (state)
      S_IDLE: begin
        rd_back = CNT_W'(1);
        if (in_valid) begin
          state_next = (fill_count >= len_clamp) ? S_LDX : S_DONE;
        end
      end
      S_LDX: begin
        rd_back    = idx_a + 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        rd_back = last_b ? idx_a + 1'b1 : idx_b + 1'b1;
        if (hit || (last_b && last_a)) begin
          state_next = S_DONE;
        end else if (last_b) begin
          state_next = S_LDX;
        end
      end
      S_DONE: begin
        if (done_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign raddr = slot_back(write_slot, rd_back);

  // Search counters and operands
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          v       <= value;
          len_eff <= len_clamp;
          idx_a   <= CNT_W'(1);
        end
      end
      S_LDX: begin
        x     <= rdata;
        idx_b <= idx_a + 1'b1;
      end
      S_CMP: begin
        if (!hit && last_b) begin
          idx_a <= idx_a + 1'b1;
        end else if (!hit) begin
          idx_b <= idx_b + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Checked and found flags
  always_ff @(posedge clk) begin
    if (rst) begin
      chk   <= 1'b0;
      found <= 1'b0;
    end else if (accept) begin
      chk   <= (fill_count >= len_clamp);
      found <= 1'b0;
    end else if (state == S_CMP && hit) begin
      found <= 1'b1;
    end
  end

  // Window position and fill level advance once the word is stored
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (done_go) begin
      write_slot <= (write_slot == AW'(WINDOW_MAX - 1)) ? '0 : write_slot + 1'b1;
      if (fill_count != CNT_W'(WINDOW_MAX)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  wpsc_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(WINDOW_MAX)
  ) u_store (
    .clk  (clk),
    .we   (done_go),
    .waddr(write_slot),
    .wdata(v),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      echo_value <= v;
      checked    <= chk;
      has_pair   <= chk && found;
    end
  end

endmodule

// File: src/wpsc_ram.sv
module wpsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/wpsc_checker.sv
module wpsc_checker
  import wpsc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [VALUE_BITS-1:0] echo_value,
  input logic                  checked,
  input logic                  has_pair
);

  // A word keeps the block busy for at least the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a word was accepted");

  // A result only appears after the block has been busy
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

  // No pair reported for an unchecked word
  a_pair_needs_check: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (checked || !has_pair))
    else $error("has_pair set on an unchecked word");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(echo_value) && $stable(checked) && $stable(has_pair)))
    else $error("stalled result changed");

endmodule

bind window_pair_sum_checker wpsc_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_wpsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .echo_value(echo_value),
  .checked   (checked),
  .has_pair  (has_pair)
);
